// ===== rtl/hpri_pkg.sv =====
// ----------------------------------------------------------------------------
// hpri_pkg
// Types and constants shared by the half-pixel row interpolator modules.
// ----------------------------------------------------------------------------
package hpri_pkg;

   // one full-pixel or half-pixel luma sample
   typedef logic [7:0] pixel_type;

   // number of cells in the tap window
   localparam int unsigned TAP_COUNT = 6;

   // register defaults and limits
   localparam int unsigned ROW_WIDTH_W     = 13;
   localparam int unsigned ROW_WIDTH_RESET = 400;
   localparam int unsigned MIN_ROW_WIDTH   = 7;

   // first column that yields a result, and first column past the left edge rule
   localparam int unsigned LEFT_EDGE_LIMIT = 3;
   localparam int unsigned LEFT_EDGE_END   = 2 * LEFT_EDGE_LIMIT;

   // extra window shifts at the end of a row (right edge padding)
   localparam logic [1:0] FLUSH_STEPS = 2'd2;
   localparam logic [1:0] FLUSH_LAST  = 2'd1;
   localparam logic [1:0] FLUSH_NONE  = 2'd0;

   // control that travels with the window into the filter stage
   typedef struct packed {
      logic valid;     // window holds a result to compute
      logic left;      // outer left taps take the first pixel of the row
      logic row_done;  // last result of the row
   } meta_type;

endpackage

// ===== rtl/hpri_tap_cell.sv =====
// ----------------------------------------------------------------------------
// hpri_tap_cell
// One cell of the tap window: holds a pixel and takes its neighbor's on shift.
// ----------------------------------------------------------------------------
module hpri_tap_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  hpri_pkg::pixel_type neighbor_pixel,
   output hpri_pkg::pixel_type pixel_out
);

   hpri_pkg::pixel_type pixel_ff;
   hpri_pkg::pixel_type pixel_in;

   // hold unless the chain shifts
   always_comb begin
      pixel_in = shift_en ? neighbor_pixel : pixel_ff;
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign pixel_out = pixel_ff;

endmodule

// ===== rtl/hpri_filter_stage.sv =====
// ----------------------------------------------------------------------------
// hpri_filter_stage
// Six-tap half-pixel filter with rounding and clipping, plus the output
// register of the result channel.
// ----------------------------------------------------------------------------
module hpri_filter_stage (
   input  logic                clock,
   input  logic                reset,
   input  hpri_pkg::pixel_type taps [hpri_pkg::TAP_COUNT],
   input  hpri_pkg::pixel_type first_pixel,
   input  hpri_pkg::meta_type  meta,
   output logic                take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_half_pixel,
   output logic                rsp_row_done
);

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   hpri_pkg::pixel_type half_ff;
   hpri_pkg::pixel_type half_in;
   logic                done_ff;
   logic                done_in;

   hpri_pkg::pixel_type tap_a;
   hpri_pkg::pixel_type tap_b;
   logic [8:0]          sum_af;
   logic [8:0]          sum_be;
   logic [8:0]          sum_cd;
   logic [13:0]         pos_sum;
   logic [11:0]         neg_sum;
   logic signed [14:0]  total;
   logic [8:0]          scaled;
   hpri_pkg::pixel_type clipped;

   // output register is free or being emptied this cycle
   assign take = !rsp_valid_ff || !rsp_stall;

   // left edge: both outer left taps repeat the first pixel of the row
   always_comb begin
      tap_a = meta.left ? first_pixel : taps[0];
      tap_b = meta.left ? first_pixel : taps[1];
   end

   // a + f - 5*(b + e) + 20*(c + d) + 16
   always_comb begin
      sum_af  = {1'b0, tap_a} + {1'b0, taps[5]};
      sum_be  = {1'b0, tap_b} + {1'b0, taps[4]};
      sum_cd  = {1'b0, taps[2]} + {1'b0, taps[3]};
      pos_sum = {5'd0, sum_af} + {1'b0, sum_cd, 4'd0} + {3'd0, sum_cd, 2'd0} + 14'd16;
      neg_sum = {1'b0, sum_be, 2'd0} + {3'd0, sum_be};
      total   = $signed({1'b0, pos_sum}) - $signed({3'b000, neg_sum});
   end

   // shift down by five, clip to 0..255
   always_comb begin
      scaled = total[13:5];
      if (total[14]) begin
         clipped = 8'd0;
      end else if (scaled[8]) begin
         clipped = 8'd255;
      end else begin
         clipped = scaled[7:0];
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      half_in      = half_ff;
      done_in      = done_ff;
      if (take) begin
         rsp_valid_in = meta.valid;
         half_in      = clipped;
         done_in      = meta.row_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      half_ff <= half_in;
      done_ff <= done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_half_pixel = half_ff;
   assign rsp_row_done   = done_ff;

endmodule

// ===== rtl/six_tap_half_pixel_row_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// six_tap_half_pixel_row_interpolator_unit
// Half-pixel luma interpolation along one row with a six-tap filter.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries full-pixel samples of a row, one per item, left to right.
//   rsp_* carries the half-pixel samples between neighboring pixels, one per
//   item; rsp_row_done marks the last one of the row (between the last two
//   pixels). csr_* writes the row width in pixels (7 up to MAX_ROW_WIDTH,
//   values outside are clipped); write it only while the block is idle.
// Timing:
//   pixels enter a chain of six tap cells. A result is computed from the
//   window and its control register and is shown on rsp_valid once the
//   output register takes it. One pixel is taken per cycle while req_stall
//   is low; after the last pixel of a row the chain shifts twice more,
//   repeating that pixel, so req_stall is high during those shifts and the
//   row's three trailing results leave back to back. W pixels yield W - 1 results.
// Reset:
//   clears the column position and both pipeline valids and sets the row
//   width to 400. When rsp_stall is high the output register holds, the
//   window stage fills, and then req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module six_tap_half_pixel_row_interpolator_unit #(
   parameter int unsigned MAX_ROW_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // pixel input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   // half-pixel output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_half_pixel,
   output logic        rsp_row_done,
   // row width register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_row_width
);

   localparam int unsigned CNT_W  = $clog2(MAX_ROW_WIDTH);
   localparam int unsigned LIM_W0 = $clog2(MAX_ROW_WIDTH + 1);
   localparam int unsigned LIM_W  = (LIM_W0 > hpri_pkg::ROW_WIDTH_W) ?
                                    LIM_W0 : hpri_pkg::ROW_WIDTH_W;

   logic [12:0]          row_width_ff;
   logic [12:0]          row_width_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [1:0]           flush_ff;
   logic [1:0]           flush_in;
   hpri_pkg::meta_type   meta_ff;
   hpri_pkg::meta_type   meta_in;
   hpri_pkg::pixel_type  first_ff;
   hpri_pkg::pixel_type  first_in;

   logic [LIM_W-1:0]     width_ext;
   logic [LIM_W-1:0]     eff_width;
   logic [LIM_W-1:0]     last_idx;
   logic [LIM_W-1:0]     count_ext;
   logic                 is_last;
   logic                 past_start;
   logic                 in_left;
   logic                 flushing;
   logic                 take;
   logic                 load_ok;
   logic                 req_take;
   logic                 flush_step;
   logic                 shift_en;
   hpri_pkg::pixel_type  chain [1:hpri_pkg::TAP_COUNT];
   hpri_pkg::pixel_type  taps  [hpri_pkg::TAP_COUNT];

   // register write port, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      row_width_in = row_width_ff;
      if (csr_valid) begin
         row_width_in = csr_row_width;
      end
   end

   // effective width and end of row test
   always_comb begin
      width_ext = LIM_W'(row_width_ff);
      if (width_ext < LIM_W'(hpri_pkg::MIN_ROW_WIDTH)) begin
         eff_width = LIM_W'(hpri_pkg::MIN_ROW_WIDTH);
      end else if (width_ext > LIM_W'(MAX_ROW_WIDTH)) begin
         eff_width = LIM_W'(MAX_ROW_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      last_idx   = eff_width - LIM_W'(1);
      count_ext  = LIM_W'(count_ff);
      is_last    = count_ext >= last_idx;
      past_start = count_ext >= LIM_W'(hpri_pkg::LEFT_EDGE_LIMIT);
      in_left    = count_ext < LIM_W'(hpri_pkg::LEFT_EDGE_END);
   end

   // handshake: the window stage loads when empty or when its result moves on
   always_comb begin
      flushing   = flush_ff != hpri_pkg::FLUSH_NONE;
      load_ok    = !meta_ff.valid || take;
      req_stall  = flushing || !load_ok;
      req_take   = req_valid && !req_stall;
      flush_step = flushing && load_ok;
      shift_en   = req_take || flush_step;
   end

   // control next state
   always_comb begin
      count_in = count_ff;
      flush_in = flush_ff;
      first_in = first_ff;
      meta_in  = meta_ff;
      if (take) begin
         meta_in.valid = 1'b0;
      end
      if (req_take) begin
         meta_in.valid    = is_last || past_start;
         meta_in.left     = !is_last && in_left;
         meta_in.row_done = 1'b0;
         if (count_ff == '0) begin
            first_in = req_pixel;
         end
         if (is_last) begin
            count_in = '0;
            flush_in = hpri_pkg::FLUSH_STEPS;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (flush_step) begin
         meta_in.valid    = 1'b1;
         meta_in.left     = 1'b0;
         meta_in.row_done = flush_ff == hpri_pkg::FLUSH_LAST;
         flush_in         = flush_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= 13'(hpri_pkg::ROW_WIDTH_RESET);
         count_ff     <= '0;
         flush_ff     <= hpri_pkg::FLUSH_NONE;
         meta_ff      <= '0;
      end else begin
         row_width_ff <= row_width_in;
         count_ff     <= count_in;
         flush_ff     <= flush_in;
         meta_ff      <= meta_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
   end

   // chain of tap cells, newest pixel at the top; padding repeats the newest
   assign chain[hpri_pkg::TAP_COUNT] = req_take ? req_pixel : taps[hpri_pkg::TAP_COUNT-1];

   for (genvar i = 0; i < hpri_pkg::TAP_COUNT; i++) begin : g_cell
      hpri_tap_cell u_cell (
         .clock          (clock),
         .shift_en       (shift_en),
         .neighbor_pixel (chain[i+1]),
         .pixel_out      (taps[i])
      );
      if (i > 0) begin : g_link
         assign chain[i] = taps[i];
      end
   end

   // filter and output register
   hpri_filter_stage u_filter (
      .clock          (clock),
      .reset          (reset),
      .taps           (taps),
      .first_pixel    (first_ff),
      .meta           (meta_ff),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_half_pixel (rsp_half_pixel),
      .rsp_row_done   (rsp_row_done)
   );

endmodule
